// File: src/gdfw_pkg.sv
// Shared widths, codes and types for the depth-first graph walk block.
package gdfw_pkg;

    localparam int NODE_W         = 5;
    localparam int OP_W           = 2;
    localparam int KIND_W         = 2;
    localparam int NODE_COUNT_DEF = 32;
    localparam int MAX_DEGREE_DEF = 8;
    localparam int S_DATA_W       = 16;
    localparam int M_DATA_W       = 8;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam op_t OP_ADD_EDGE = 2'd0;
    localparam op_t OP_WALK     = 2'd1;
    localparam op_t OP_CLEAR    = 2'd2;
    localparam op_t OP_NONE     = 2'd3;

    localparam kind_t KIND_EDGE  = 2'd0;
    localparam kind_t KIND_VISIT = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_E_RD,
        ST_E_WR,
        ST_ACK,
        ST_W_START,
        ST_W_DEG,
        ST_W_DEGD,
        ST_W_CHK,
        ST_W_NB,
        ST_W_VIS,
        ST_W_POP,
        ST_W_END
    } state_t;

endpackage

// File: src/gdfw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/graph_depth_first_walk.sv
// Depth-first graph walk over per-node neighbor lists: sequencer and storage.
// Add edge: read list length, write entry; undirected repeats this for the reverse arc.
// Clear: sweeps the visit marks to zero. Walk: each step makes one registered read
// of a list, degree, mark or stack memory.
// One item at a time; s_tready is high only between items.
// After rst_n deasserts, a sweep zeroes list lengths and visit marks;
// s_tready stays low until it ends.
module graph_depth_first_walk #(
    parameter int NODE_COUNT = gdfw_pkg::NODE_COUNT_DEF,
    parameter int MAX_DEGREE = gdfw_pkg::MAX_DEGREE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gdfw_pkg::S_DATA_W-1:0] s_tdata,  // node_a, node_b, undirected
    input  logic [gdfw_pkg::OP_W-1:0]     s_tuser,  // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gdfw_pkg::M_DATA_W-1:0] m_tdata,  // visited_node, list_full
    output logic [gdfw_pkg::KIND_W-1:0]   m_tuser,  // result_kind
    output logic                          m_tlast   // last
);

    import gdfw_pkg::*;

    localparam int NI    = $clog2(NODE_COUNT);
    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int NB_AW = $clog2(NODE_COUNT * MAX_DEGREE);
    localparam int STK_W = NODE_W + DEG_W;

    state_t state_reg, state_next;
    logic [NI-1:0] clr_reg, clr_next;
    logic sweep_deg_reg, sweep_deg_next;
    logic [NI-1:0] sp_reg, sp_next;
    logic m_valid_reg, m_valid_next;

    op_t op_reg, op_next;
    node_t a_reg, a_next;
    node_t b_reg, b_next;
    logic und_reg, und_next;
    logic second_reg, second_next;
    logic full_reg, full_next;
    node_t cur_reg, cur_next;
    logic [DEG_W-1:0] pos_reg, pos_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    node_t nb_reg, nb_next;
    node_t pend_reg, pend_next;
    kind_t m_kind_reg, m_kind_next;
    node_t m_node_reg, m_node_next;
    logic m_full_reg, m_full_next;
    logic m_last_reg, m_last_next;

    logic nb_we;
    logic [NB_AW-1:0] nb_waddr, nb_raddr;
    node_t nb_wdata, nb_rdata;
    logic deg_we;
    logic [NI-1:0] deg_waddr, deg_raddr;
    logic [DEG_W-1:0] deg_wdata, deg_rdata;
    logic vis_we;
    logic [NI-1:0] vis_waddr, vis_raddr;
    logic vis_wdata, vis_rdata;
    logic stk_we;
    logic [NI-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0] stk_wdata, stk_rdata;

    node_t src, dst;
    logic can_send;

    function automatic logic in_range(input node_t n);
        return (32'(n) < 32'(NODE_COUNT));
    endfunction

    function automatic logic [NB_AW-1:0] list_addr(input node_t n, input logic [DEG_W-1:0] p);
        return NB_AW'(int'(n) * MAX_DEGREE + int'(p));
    endfunction

    gdfw_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT * MAX_DEGREE)) u_nbr_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    gdfw_ram #(.WIDTH(DEG_W), .DEPTH(NODE_COUNT)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    gdfw_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    gdfw_ram #(.WIDTH(STK_W), .DEPTH(NODE_COUNT)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign src      = second_reg ? b_reg : a_reg;
    assign dst      = second_reg ? a_reg : b_reg;
    assign can_send = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - NODE_W - 1){1'b0}}, m_full_reg, m_node_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            clr_reg       <= '0;
            sweep_deg_reg <= 1'b1;
            sp_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sweep_deg_reg <= sweep_deg_next;
            sp_reg        <= sp_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        und_reg    <= und_next;
        second_reg <= second_next;
        full_reg   <= full_next;
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        deg_reg    <= deg_next;
        nb_reg     <= nb_next;
        pend_reg   <= pend_next;
        m_kind_reg <= m_kind_next;
        m_node_reg <= m_node_next;
        m_full_reg <= m_full_next;
        m_last_reg <= m_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sweep_deg_next = sweep_deg_reg;
        sp_next        = sp_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        und_next       = und_reg;
        second_next    = second_reg;
        full_next      = full_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        deg_next       = deg_reg;
        nb_next        = nb_reg;
        pend_next      = pend_reg;
        m_kind_next    = m_kind_reg;
        m_node_next    = m_node_reg;
        m_full_next    = m_full_reg;
        m_last_next    = m_last_reg;

        nb_we     = 1'b0;
        nb_waddr  = list_addr(src, deg_rdata);
        nb_wdata  = dst;
        nb_raddr  = list_addr(cur_reg, pos_reg);
        deg_we    = 1'b0;
        deg_waddr = sweep_deg_reg ? clr_reg : NI'(src);
        deg_wdata = sweep_deg_reg ? '0 : deg_rdata + 1'b1;
        deg_raddr = (state_reg == ST_E_RD) ? NI'(src) : NI'(cur_reg);
        vis_we    = 1'b0;
        vis_waddr = clr_reg;
        vis_wdata = 1'b0;
        vis_raddr = (state_reg == ST_W_NB) ? NI'(nb_rdata) : NI'(nb_reg);
        stk_we    = 1'b0;
        stk_waddr = sp_reg;
        stk_wdata = {cur_reg, pos_reg};
        stk_raddr = sp_reg - 1'b1;

        unique case (state_reg)
            ST_SWEEP:
            begin
                vis_we = 1'b1;
                deg_we = sweep_deg_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NI'(NODE_COUNT - 1))
                begin
                    clr_next = '0;
                    sweep_deg_next = 1'b0;
                    state_next = sweep_deg_reg ? ST_IDLE : ST_ACK;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    a_next      = s_tdata[NODE_W-1:0];
                    b_next      = s_tdata[2*NODE_W-1:NODE_W];
                    und_next    = s_tdata[2*NODE_W];
                    second_next = 1'b0;
                    full_next   = 1'b0;
                    unique case (s_tuser)
                        OP_ADD_EDGE: state_next = ST_E_RD;
                        OP_WALK:     state_next = ST_W_START;
                        OP_CLEAR:    state_next = ST_SWEEP;
                        OP_NONE:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_WR;
            end
            ST_E_WR:
            begin
                if (in_range(src) && in_range(dst))
                begin
                    if (deg_rdata < DEG_W'(MAX_DEGREE))
                    begin
                        nb_we  = 1'b1;
                        deg_we = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                if (!second_reg && und_reg)
                begin
                    second_next = 1'b1;
                    state_next  = ST_E_RD;
                end
                else
                begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (can_send)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = (op_reg == OP_ADD_EDGE) ? KIND_EDGE : KIND_CLEAR;
                    m_node_next  = '0;
                    m_full_next  = full_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_W_START:
            begin
                pend_next = a_reg;
                cur_next  = a_reg;
                pos_next  = '0;
                sp_next   = '0;
                if (in_range(a_reg))
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = NI'(a_reg);
                    vis_wdata  = 1'b1;
                    state_next = ST_W_DEG;
                end
                else
                begin
                    state_next = ST_W_END;
                end
            end
            ST_W_DEG:
            begin
                state_next = ST_W_DEGD;
            end
            ST_W_DEGD:
            begin
                deg_next   = deg_rdata;
                state_next = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (pos_reg < deg_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_W_NB;
                end
                else if (sp_reg == '0)
                begin
                    state_next = ST_W_END;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_W_POP;
                end
            end
            ST_W_NB:
            begin
                nb_next    = nb_rdata;
                state_next = ST_W_VIS;
            end
            ST_W_VIS:
            begin
                if (!in_range(nb_reg) || vis_rdata)
                begin
                    state_next = ST_W_CHK;
                end
                else if (can_send)
                begin
                    // the held report is not the last one: a new node follows it
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_VISIT;
                    m_node_next  = pend_reg;
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b0;
                    pend_next    = nb_reg;
                    vis_we       = 1'b1;
                    vis_waddr    = NI'(nb_reg);
                    vis_wdata    = 1'b1;
                    stk_we       = 1'b1;
                    sp_next      = sp_reg + 1'b1;
                    cur_next     = nb_reg;
                    pos_next     = '0;
                    state_next   = ST_W_DEG;
                end
            end
            ST_W_POP:
            begin
                cur_next   = stk_rdata[STK_W-1:DEG_W];
                pos_next   = stk_rdata[DEG_W-1:0];
                state_next = ST_W_DEG;
            end
            ST_W_END:
            begin
                if (can_send)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_VISIT;
                    m_node_next  = pend_reg;
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/gdfw_check.sv
// Port-level checks for the depth-first graph walk block, bound to the top level.
module gdfw_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gdfw_pkg::S_DATA_W-1:0] s_tdata,
    input logic [gdfw_pkg::OP_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gdfw_pkg::M_DATA_W-1:0] m_tdata,
    input logic [gdfw_pkg::KIND_W-1:0]   m_tuser,
    input logic                          m_tlast
);

    import gdfw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != OP_NONE |=> !s_tready)
        else $error("input taken again while an item is in progress");

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_VISIT |-> m_tlast)
        else $error("acknowledge word not marked last");

    a_ack_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_VISIT |-> m_tdata[NODE_W-1:0] == '0)
        else $error("acknowledge word carries a node");

    a_visit_no_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_VISIT |-> !m_tdata[NODE_W])
        else $error("visit word flags a full list");

endmodule

bind graph_depth_first_walk gdfw_check u_gdfw_check (.*);

// File: verif/tb.sv
// Testbench for graph_depth_first_walk: directed table, then random traffic checked by a predictor.
`timescale 1ns / 100ps

module tb;

    import gdfw_pkg::*;

    localparam int NODES          = NODE_COUNT_DEF;
    localparam int DEG            = MAX_DEGREE_DEF;
    localparam int IDLE_LIMIT     = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 300;
    localparam int RAND_PER_PHASE = 60;
    localparam int DIR_ROWS       = 23;

    typedef struct {
        kind_t kind;
        node_t node;
        bit    full;
        bit    last;
    } report_t;

    // typed = 1: the row carries its own single expected word
    typedef struct {
        op_t   op;
        node_t a;
        node_t b;
        bit    und;
        bit    typed;
        kind_t kind;
        node_t node;
        bit    full;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    op_t                   s_tuser  = OP_NONE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    kind_t                 m_tuser;
    logic                  m_tlast;

    // graph image kept by the testbench
    node_t adj [NODES][DEG];
    int    deg_cnt [NODES];
    bit    seen [NODES];

    report_t step_reports [$];
    report_t due_reports [$];

    int fail_cnt;
    int n_items;
    int n_walks;
    int n_full_flags;
    int n_checked;
    int quiet_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_left;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{OP_WALK,     5'd0,  5'd0,  1'b0, 1'b1, KIND_VISIT, 5'd0, 1'b0}, // empty graph
        '{OP_NONE,     5'd31, 5'd31, 1'b1, 1'b0, KIND_EDGE,  5'd0, 1'b0}, // ignored
        '{OP_ADD_EDGE, 5'd0,  5'd1,  1'b0, 1'b1, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd1,  5'd2,  1'b1, 1'b1, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd2,  5'd31, 1'b1, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd5,  5'd5,  1'b1, 1'b0, KIND_EDGE,  5'd0, 1'b0}, // self edge
        '{OP_ADD_EDGE, 5'd31, 5'd5,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd6,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd7,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd8,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd9,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd10, 1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd11, 1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd12, 1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd13, 1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_ADD_EDGE, 5'd3,  5'd4,  1'b1, 1'b1, KIND_EDGE,  5'd0, 1'b1}, // 3 is full
        '{OP_WALK,     5'd0,  5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_WALK,     5'd0,  5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0}, // start seen
        '{OP_WALK,     5'd3,  5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_CLEAR,    5'd0,  5'd0,  1'b0, 1'b1, KIND_CLEAR, 5'd0, 1'b0},
        '{OP_WALK,     5'd31, 5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_WALK,     5'd4,  5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0},
        '{OP_NONE,     5'd0,  5'd0,  1'b0, 1'b0, KIND_EDGE,  5'd0, 1'b0}
    };

    graph_depth_first_walk dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void add_step(report_t r);
        step_reports.insert(step_reports.size(), r);
    endfunction

    function automatic void add_due(report_t r);
        due_reports.insert(due_reports.size(), r);
    endfunction

    function automatic bit append_arc(node_t src, node_t dst);
        if (deg_cnt[src] >= DEG)
            return 1'b1;
        adj[src][deg_cnt[src]] = dst;
        deg_cnt[src]++;
        return 1'b0;
    endfunction

    // Updates the graph image and fills step_reports with the words one item causes.
    function automatic void graph_item_reports(op_t op, node_t a, node_t b, bit und);
        bit    full;
        node_t order [$];
        node_t frame_node [NODES];
        int    frame_pos [NODES];
        int    top;
        int    f;
        node_t cur;
        node_t nb;
        step_reports.delete();
        case (op)
            OP_ADD_EDGE:
            begin
                full = append_arc(a, b);
                if (und)
                    full |= append_arc(b, a);
                add_step('{KIND_EDGE, '0, full, 1'b1});
            end
            OP_CLEAR:
            begin
                foreach (seen[i])
                    seen[i] = 1'b0;
                add_step('{KIND_CLEAR, '0, 1'b0, 1'b1});
            end
            OP_WALK:
            begin
                order.insert(order.size(), a);
                seen[a]       = 1'b1;
                frame_node[0] = a;
                frame_pos[0]  = 0;
                top           = 1;
                while (top > 0)
                begin
                    f   = top - 1;
                    cur = frame_node[f];
                    if (frame_pos[f] >= deg_cnt[cur])
                        top--;
                    else
                    begin
                        nb = adj[cur][frame_pos[f]];
                        frame_pos[f]++;
                        if (!seen[nb])
                        begin
                            seen[nb] = 1'b1;
                            order.insert(order.size(), nb);
                            frame_node[top] = nb;
                            frame_pos[top]  = 0;
                            top++;
                        end
                    end
                end
                foreach (order[i])
                    add_step('{KIND_VISIT, order[i], 1'b0, i == order.size() - 1});
            end
            default: ;
        endcase
    endfunction

    // Offers one word on the input side; returns just after the accepting edge.
    task automatic offer_item(stim_row_t r);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({r.und, r.b, r.a});
        s_tuser  <= r.op;
        do
            @(posedge clk);
        while (!s_tready);
        graph_item_reports(r.op, r.a, r.b, r.und);
        if (r.op != OP_NONE)
            n_items++;
        if (r.op == OP_WALK)
            n_walks++;
        foreach (step_reports[i])
            if (step_reports[i].full)
                n_full_flags++;
        if (r.typed)
            add_due('{r.kind, r.node, r.full, 1'b1});
        else
            foreach (step_reports[i])
                add_due(step_reports[i]);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_reports.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d node %0d",
                       m_tuser, m_tdata[4:0]);
                fail_cnt++;
            end
            else
            begin
                want = due_reports.pop_front();
                n_checked++;
                if (m_tuser !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata[4:0] !== want.node)
                begin
                    $error("visited_node: expected %0d, got %0d", want.node, m_tdata[4:0]);
                    fail_cnt++;
                end
                if (m_tdata[5] !== want.full)
                begin
                    $error("list_full: expected %0d, got %0d", want.full, m_tdata[5]);
                    fail_cnt++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        int        sent;
        int        pick;
        tx_idle_pct = 16;
        rx_idle_pct = 70;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_item(dir_rows[i]);

        // long output stall while input keeps offering
        hold_req++;
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 70 : 0;
            rx_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 16 : 0;
            sent = 0;
            while (sent < RAND_PER_PHASE)
            begin
                pick      = $urandom_range(99);
                // bias toward low nodes so some lists fill up
                row.a     = ($urandom_range(2) == 0) ? node_t'($urandom_range(7))
                                                     : node_t'($urandom_range(31));
                row.b     = node_t'($urandom_range(31));
                row.und   = 1'($urandom_range(1));
                row.typed = 1'b0;
                row.kind  = KIND_EDGE;
                row.node  = '0;
                row.full  = 1'b0;
                if (pick < 45)
                    row.op = OP_ADD_EDGE;
                else if (pick < 82)
                    row.op = OP_WALK;
                else if (pick < 92)
                    row.op = OP_CLEAR;
                else
                    row.op = OP_NONE;
                offer_item(row);
                if (row.op != OP_NONE)
                    sent++;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d items (%0d walks), %0d result words compared",
                 n_items, n_walks, n_checked);
        $display("run: %0d full-list adds; three idle mixes plus one long output stall",
                 n_full_flags);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
